[hw/rtl/cbm_pkg.sv]
`default_nettype none

package cbm_pkg;

    // Item kinds carried on the mode field
    typedef enum logic [1:0] {
        MODE_WRITE = 2'd0,
        MODE_CPU   = 2'd1,
        MODE_PPU   = 2'd2,
        MODE_TICK  = 2'd3
    } mode_t;

    // Destination of a translated access
    typedef enum logic [1:0] {
        TGT_PRG      = 2'd0,
        TGT_RAM      = 2'd1,
        TGT_CHR      = 2'd2,
        TGT_UNMAPPED = 2'd3
    } target_t;

    // Command register codes (CHR banks use codes 0 through 7)
    localparam logic [3:0] CMD_CHR_LAST = 4'h7;
    localparam logic [3:0] CMD_WINDOW   = 4'h8;
    localparam logic [3:0] CMD_PRG_0    = 4'h9;
    localparam logic [3:0] CMD_PRG_2    = 4'hB;
    localparam logic [3:0] CMD_MIRROR   = 4'hC;
    localparam logic [3:0] CMD_IRQ      = 4'hD;
    localparam logic [3:0] CMD_COUNT_LO = 4'hE;
    localparam logic [3:0] CMD_COUNT_HI = 4'hF;

    // CPU address decode on address[15:13]
    localparam logic [2:0] WIN_WINDOW  = 3'b011;
    localparam logic [2:0] WIN_COMMAND = 3'b100;
    localparam logic [2:0] WIN_PARAM   = 3'b101;
    localparam logic [2:0] WIN_FIXED   = 3'b111;

    // Number of PRG banks; the top CPU window maps to the last one
    localparam int          PRG_BANK_COUNT = 64;
    localparam logic [7:0]  PRG_LAST_BANK  = 8'((PRG_BANK_COUNT - 1) & 8'hFF);

    // Mapper state
    typedef struct packed {
        logic [3:0]       command_select;
        logic [7:0][7:0]  chr_banks;
        logic [2:0][7:0]  prg_banks;
        logic [7:0]       window_bank;
        logic             window_is_ram;
        logic [1:0]       mirror_mode;
        logic             irq_enable;
        logic             counter_enable;
        logic [15:0]      down_count;
        logic             irq_pending;
    } state_t;

endpackage

`default_nettype wire

[hw/rtl/cbm_regs.sv]
`default_nettype none

module cbm_regs (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             advance,
    input  wire logic [1:0]       mode,
    input  wire logic [15:0]      address,
    input  wire logic [7:0]       data,
    output cbm_pkg::state_t       st,
    output logic                  irq_next,
    output logic [1:0]            mirror_next
);

    cbm_pkg::state_t st_reg;
    cbm_pkg::state_t st_next;
    logic [15:0]     count_dec;
    logic [1:0]      prg_sel;

    assign count_dec = st_reg.down_count - 16'd1;
    assign prg_sel   = 2'(st_reg.command_select - cbm_pkg::CMD_PRG_0);

    // Next state: command/parameter writes and counter ticks
    always_comb
    begin
        st_next = st_reg;
        case (cbm_pkg::mode_t'(mode))
            cbm_pkg::MODE_WRITE:
            begin
                if (address[15:13] == cbm_pkg::WIN_COMMAND)
                begin
                    st_next.command_select = data[3:0];
                end
                else if (address[15:13] == cbm_pkg::WIN_PARAM)
                begin
                    case (st_reg.command_select) inside
                        [4'h0:cbm_pkg::CMD_CHR_LAST]:
                            st_next.chr_banks[st_reg.command_select[2:0]] = data;
                        cbm_pkg::CMD_WINDOW:
                        begin
                            // RAM selected while RAM disabled: write dropped
                            if (!data[6] || data[7])
                            begin
                                st_next.window_bank   = data;
                                st_next.window_is_ram = data[6];
                            end
                        end
                        [cbm_pkg::CMD_PRG_0:cbm_pkg::CMD_PRG_2]:
                            st_next.prg_banks[prg_sel] = data;
                        cbm_pkg::CMD_MIRROR:
                            st_next.mirror_mode = data[1:0];
                        cbm_pkg::CMD_IRQ:
                        begin
                            st_next.irq_enable     = data[0];
                            st_next.counter_enable = data[7];
                            if (!data[7])
                            begin
                                st_next.irq_pending = 1'b0;
                            end
                        end
                        cbm_pkg::CMD_COUNT_LO:
                            st_next.down_count[7:0] = data;
                        cbm_pkg::CMD_COUNT_HI:
                            st_next.down_count[15:8] = data;
                        default:
                            st_next = st_reg;
                    endcase
                end
            end
            cbm_pkg::MODE_TICK:
            begin
                if (st_reg.counter_enable)
                begin
                    st_next.down_count = count_dec;
                    if (count_dec == 16'd0 && st_reg.irq_enable)
                    begin
                        st_next.irq_pending = 1'b1;
                    end
                end
            end
            default:
                st_next = st_reg;
        endcase
    end

    // State register, updated once per beat moving to the result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= '0;
        end
        else if (advance)
        begin
            st_reg <= st_next;
        end
    end

    assign st          = st_reg;
    assign irq_next    = st_next.irq_pending;
    assign mirror_next = st_next.mirror_mode;

endmodule

`default_nettype wire

[hw/rtl/cbm_xlate.sv]
`default_nettype none

module cbm_xlate (
    input  cbm_pkg::state_t       st,
    input  wire logic [1:0]       mode,
    input  wire logic [15:0]      address,
    output logic [7:0]            bank,
    output logic [12:0]           offset,
    output logic [1:0]            target
);

    logic [7:0] prg_bank;

    // Switchable 8 KiB PRG slots at 0x8000, 0xA000, 0xC000
    always_comb
    begin
        case (address[14:13])
            2'd0:    prg_bank = st.prg_banks[0];
            2'd1:    prg_bank = st.prg_banks[1];
            2'd2:    prg_bank = st.prg_banks[2];
            default: prg_bank = st.prg_banks[2];
        endcase
    end

    // Address translation; writes and ticks come out unmapped
    always_comb
    begin
        bank   = 8'd0;
        offset = 13'd0;
        target = cbm_pkg::TGT_UNMAPPED;
        case (cbm_pkg::mode_t'(mode))
            cbm_pkg::MODE_CPU:
            begin
                if (address[15:13] == cbm_pkg::WIN_WINDOW)
                begin
                    bank   = st.window_bank;
                    offset = address[12:0];
                    target = st.window_is_ram ? cbm_pkg::TGT_RAM : cbm_pkg::TGT_PRG;
                end
                else if (address[15:13] == cbm_pkg::WIN_FIXED)
                begin
                    bank   = cbm_pkg::PRG_LAST_BANK;
                    offset = address[12:0];
                    target = cbm_pkg::TGT_PRG;
                end
                else if (address[15])
                begin
                    bank   = prg_bank;
                    offset = address[12:0];
                    target = cbm_pkg::TGT_PRG;
                end
            end
            cbm_pkg::MODE_PPU:
            begin
                bank   = st.chr_banks[address[12:10]];
                offset = {3'd0, address[9:0]};
                target = cbm_pkg::TGT_CHR;
            end
            default:
            begin
                bank   = 8'd0;
                offset = 13'd0;
                target = cbm_pkg::TGT_UNMAPPED;
            end
        endcase
    end

endmodule

`default_nettype wire

[hw/rtl/cartridge_bank_mapper_irq_top.sv]
// Cartridge bank mapper with IRQ down counter.
// Input channel (in_valid / in_stall) carries one beat per item: mode
// selects a CPU write, a CPU address translate, a PPU pattern address
// translate or a CPU cycle tick; address and data go with it.
// Output channel (out_valid / out_stall) returns exactly one beat per item:
// bank, offset and target for translates (unmapped for writes and ticks),
// plus irq_line and mirroring as they stand after that item.
// An accepted item moves from the input register to the result register.
// One item per clock while the receiver does not stall; the input register
// feeds the state update and translate logic, which load the result register.
// When the receiver stalls, the result register holds its beat; the input
// register can still take one more beat, after which in_stall rises until
// the result is taken.
// Reset clears all bank, mirroring, IRQ and counter state to zero and
// empties both pipeline registers.
`default_nettype none

module cartridge_bank_mapper_irq_top (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_stall,
    input  wire logic [1:0]   mode,
    input  wire logic [15:0]  address,
    input  wire logic [7:0]   data,
    output logic              out_valid,
    input  wire logic         out_stall,
    output logic [7:0]        bank,
    output logic [12:0]       offset,
    output logic [1:0]        target,
    output logic              irq_line,
    output logic [1:0]        mirroring
);

    logic            in_valid_reg;
    logic [1:0]      mode_reg;
    logic [15:0]     address_reg;
    logic [7:0]      data_reg;

    logic            out_valid_reg;
    logic [7:0]      bank_reg;
    logic [12:0]     offset_reg;
    logic [1:0]      target_reg;
    logic            irq_reg;
    logic [1:0]      mirror_reg;

    logic            advance;
    cbm_pkg::state_t st;
    logic            irq_next;
    logic [1:0]      mirror_next;
    logic [7:0]      bank_next;
    logic [12:0]     offset_next;
    logic [1:0]      target_next;

    // Handshake: input stage moves on whenever the result slot is free
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && out_valid_reg && out_stall;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            mode_reg    <= mode;
            address_reg <= address;
            data_reg    <= data;
        end
    end

    cbm_regs u_regs (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .mode        (mode_reg),
        .address     (address_reg),
        .data        (data_reg),
        .st          (st),
        .irq_next    (irq_next),
        .mirror_next (mirror_next)
    );

    cbm_xlate u_xlate (
        .st      (st),
        .mode    (mode_reg),
        .address (address_reg),
        .bank    (bank_next),
        .offset  (offset_next),
        .target  (target_next)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            bank_reg   <= bank_next;
            offset_reg <= offset_next;
            target_reg <= target_next;
            irq_reg    <= irq_next;
            mirror_reg <= mirror_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign bank      = bank_reg;
    assign offset    = offset_reg;
    assign target    = target_reg;
    assign irq_line  = irq_reg;
    assign mirroring = mirror_reg;

endmodule

`default_nettype wire

[tb/cartridge_bank_mapper_irq_top_test.sv]
`default_nettype none

module cartridge_bank_mapper_irq_top_test;

    import cbm_pkg::*;

    localparam int unsigned RANDOM_ITEMS = 1300;
    localparam int unsigned QUIET_ITEMS  = 150;
    localparam int unsigned HOLD_CYCLES  = 60;
    localparam int unsigned STALL_LIMIT  = 2000;
    localparam int unsigned DRAIN_CYCLES = 4;

    // One access as offered on the input channel
    typedef struct packed {
        mode_t       mode;
        logic [15:0] addr;
        logic [7:0]  data;
    } access_t;

    // One translated result beat
    typedef struct packed {
        logic [7:0]  bank;
        logic [12:0] offset;
        target_t     target;
        logic        irq;
        logic [1:0]  mirror;
    } mapped_t;

    // Directed row: access plus an optional hand-written result
    typedef struct packed {
        access_t acc;
        logic    typed;
        mapped_t res;
    } stim_row_t;

    localparam mapped_t NO_RES = '{8'h00, 13'h0000, TGT_UNMAPPED, 1'b0, 2'd0};

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    mode_t       mode;
    logic [15:0] address;
    logic [7:0]  data;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  bank;
    logic [12:0] offset;
    logic [1:0]  target;
    logic        irq_line;
    logic [1:0]  mirroring;

    // Mapper state as predicted from accepted beats
    logic [3:0]  cur_cmd = '0;
    logic [7:0]  chr_sel [8] = '{default: 8'h00};
    logic [7:0]  prg_sel [3] = '{default: 8'h00};
    logic [7:0]  win_bank = '0;
    logic        win_ram = 1'b0;
    logic [1:0]  mirror_sel = '0;
    logic        irq_en = 1'b0;
    logic        count_en = 1'b0;
    logic [15:0] tick_count = '0;
    logic        irq_flag = 1'b0;

    mapped_t     expected_q [$];
    access_t     plan_q [$];
    int unsigned mismatches = 0;
    int unsigned idle_cycles = 0;
    logic        quiet = 1'b0;
    logic        long_hold_req = 1'b0;

    // Directed accesses: reset values, address extremes, ignored writes,
    // window RAM-disabled write, command nibble, IRQ arm, fire and clear
    stim_row_t directed_rows [25] = '{
        '{'{MODE_CPU,   16'h0000, 8'h00}, 1'b1, '{8'h00, 13'h0000, TGT_UNMAPPED, 1'b0, 2'd0}},
        '{'{MODE_CPU,   16'hFFFF, 8'h00}, 1'b1, '{PRG_LAST_BANK, 13'h1FFF, TGT_PRG, 1'b0, 2'd0}},
        '{'{MODE_PPU,   16'hFFFF, 8'hFF}, 1'b1, '{8'h00, 13'h03FF, TGT_CHR, 1'b0, 2'd0}},
        '{'{MODE_WRITE, 16'h8000, 8'hF8}, 1'b1, NO_RES},
        '{'{MODE_WRITE, 16'hBFFF, 8'h40}, 1'b1, NO_RES},
        '{'{MODE_CPU,   16'h6000, 8'h00}, 1'b1, '{8'h00, 13'h0000, TGT_PRG, 1'b0, 2'd0}},
        '{'{MODE_WRITE, 16'hA000, 8'hFF}, 1'b0, NO_RES},
        '{'{MODE_CPU,   16'h7FFF, 8'h00}, 1'b0, NO_RES},
        '{'{MODE_WRITE, 16'h9FFF, 8'h0C}, 1'b0, NO_RES},
        '{'{MODE_WRITE, 16'hA000, 8'h03}, 1'b0, NO_RES},
        '{'{MODE_WRITE, 16'h7FFF, 8'h0D}, 1'b0, NO_RES},
        '{'{MODE_WRITE, 16'hC000, 8'h09}, 1'b0, NO_RES},
        '{'{MODE_WRITE, 16'h8000, 8'h19}, 1'b0, NO_RES},
        '{'{MODE_WRITE, 16'hA123, 8'hAB}, 1'b0, NO_RES},
        '{'{MODE_CPU,   16'h8000, 8'h00}, 1'b0, NO_RES},
        '{'{MODE_WRITE, 16'h8000, 8'h07}, 1'b0, NO_RES},
        '{'{MODE_WRITE, 16'hA000, 8'h80}, 1'b0, NO_RES},
        '{'{MODE_PPU,   16'h1C05, 8'h00}, 1'b0, NO_RES},
        '{'{MODE_WRITE, 16'h8000, 8'h0E}, 1'b0, NO_RES},
        '{'{MODE_WRITE, 16'hA000, 8'h02}, 1'b0, NO_RES},
        '{'{MODE_WRITE, 16'h8000, 8'h0D}, 1'b0, NO_RES},
        '{'{MODE_WRITE, 16'hA000, 8'h81}, 1'b0, NO_RES},
        '{'{MODE_TICK,  16'h1234, 8'h55}, 1'b0, NO_RES},
        '{'{MODE_TICK,  16'hEDCB, 8'hAA}, 1'b0, NO_RES},
        '{'{MODE_WRITE, 16'hA000, 8'h01}, 1'b0, NO_RES}
    };

    cartridge_bank_mapper_irq_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .mode      (mode),
        .address   (address),
        .data      (data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .bank      (bank),
        .offset    (offset),
        .target    (target),
        .irq_line  (irq_line),
        .mirroring (mirroring)
    );

    // Clock and reset
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        rst_n <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Applies one access to the predicted state and returns its result
    function automatic mapped_t translate_access(input access_t acc);
        mapped_t r;
        r = NO_RES;
        case (acc.mode)
            MODE_WRITE:
            begin
                if (acc.addr[15:13] == WIN_COMMAND)
                    cur_cmd = acc.data[3:0];
                else if (acc.addr[15:13] == WIN_PARAM)
                begin
                    if (cur_cmd <= CMD_CHR_LAST)
                        chr_sel[cur_cmd[2:0]] = acc.data;
                    else
                    begin
                        case (cur_cmd)
                            // RAM source with RAM disabled leaves the window alone
                            CMD_WINDOW:
                                if (!acc.data[6] || acc.data[7])
                                begin
                                    win_bank = acc.data;
                                    win_ram  = acc.data[6];
                                end
                            CMD_MIRROR:   mirror_sel = acc.data[1:0];
                            CMD_IRQ:
                            begin
                                irq_en   = acc.data[0];
                                count_en = acc.data[7];
                                if (!acc.data[7])
                                    irq_flag = 1'b0;
                            end
                            CMD_COUNT_LO: tick_count[7:0]  = acc.data;
                            CMD_COUNT_HI: tick_count[15:8] = acc.data;
                            // CMD_PRG_0 through CMD_PRG_2
                            default:      prg_sel[2'(cur_cmd - CMD_PRG_0)] = acc.data;
                        endcase
                    end
                end
            end
            MODE_CPU:
            begin
                if (acc.addr[15:13] >= WIN_WINDOW)
                begin
                    r.offset = acc.addr[12:0];
                    r.target = TGT_PRG;
                    if (acc.addr[15:13] == WIN_WINDOW)
                    begin
                        r.bank   = win_bank;
                        r.target = win_ram ? TGT_RAM : TGT_PRG;
                    end
                    else if (acc.addr[15:13] == WIN_FIXED)
                        r.bank = PRG_LAST_BANK;
                    else
                        r.bank = prg_sel[acc.addr[14:13]];
                end
            end
            MODE_PPU:
            begin
                r.bank   = chr_sel[acc.addr[12:10]];
                r.offset = {3'b000, acc.addr[9:0]};
                r.target = TGT_CHR;
            end
            MODE_TICK:
            begin
                if (count_en)
                begin
                    tick_count = tick_count - 16'd1;
                    if (tick_count == 16'd0 && irq_en)
                        irq_flag = 1'b1;
                end
            end
        endcase
        r.irq    = irq_flag;
        r.mirror = mirror_sel;
        return r;
    endfunction

    function automatic void queue_access(input mode_t m, input logic [15:0] ad,
                                         input logic [7:0] d);
        access_t acc;
        acc.mode = m;
        acc.addr = ad;
        acc.data = d;
        plan_q.push_back(acc);
    endfunction

    // Random traffic, mostly command/parameter pairs, counter setups
    // followed by ticks, and translates; a little raw noise
    function automatic void plan_sequence();
        int unsigned pick;
        int unsigned n;
        pick = $urandom_range(0, 99);
        if (pick < 30)
        begin
            queue_access(MODE_WRITE, {WIN_COMMAND, 13'($urandom)}, 8'($urandom));
            queue_access(MODE_WRITE, {WIN_PARAM, 13'($urandom)}, 8'($urandom));
            queue_access($urandom_range(0, 1) ? MODE_CPU : MODE_PPU, 16'($urandom),
                         8'($urandom));
        end
        else if (pick < 45)
        begin
            queue_access(MODE_WRITE, {WIN_COMMAND, 13'($urandom)},
                         {4'($urandom), CMD_COUNT_LO});
            queue_access(MODE_WRITE, {WIN_PARAM, 13'($urandom)}, 8'($urandom_range(0, 12)));
            queue_access(MODE_WRITE, {WIN_COMMAND, 13'($urandom)},
                         {4'($urandom), CMD_COUNT_HI});
            queue_access(MODE_WRITE, {WIN_PARAM, 13'($urandom)},
                         ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h00);
            queue_access(MODE_WRITE, {WIN_COMMAND, 13'($urandom)}, {4'($urandom), CMD_IRQ});
            queue_access(MODE_WRITE, {WIN_PARAM, 13'($urandom)},
                         {1'($urandom_range(0, 4) != 0), 6'($urandom),
                          1'($urandom_range(0, 3) != 0)});
            n = $urandom_range(1, 20);
            repeat (n) queue_access(MODE_TICK, 16'($urandom), 8'($urandom));
        end
        else if (pick < 60)
        begin
            n = $urandom_range(1, 16);
            repeat (n) queue_access(MODE_TICK, 16'($urandom), 8'($urandom));
        end
        else if (pick < 80)
        begin
            n = $urandom_range(1, 4);
            repeat (n) queue_access(MODE_CPU, 16'($urandom), 8'($urandom));
        end
        else if (pick < 92)
        begin
            n = $urandom_range(1, 4);
            repeat (n) queue_access(MODE_PPU, 16'($urandom), 8'($urandom));
        end
        else
        begin
            n = $urandom_range(1, 3);
            repeat (n) queue_access(mode_t'($urandom_range(0, 3)), 16'($urandom),
                                    8'($urandom));
        end
    endfunction

    // Offer one beat and hold it until taken; valid stays up afterwards
    task automatic offer(input access_t acc, input logic typed, input mapped_t typed_res);
        mapped_t want;
        in_valid <= 1'b1;
        mode     <= acc.mode;
        address  <= acc.addr;
        data     <= acc.data;
        do @(posedge clk); while (in_stall);
        want = translate_access(acc);
        expected_q.push_back(typed ? typed_res : want);
    endtask

    task automatic sender_gap();
        if (!quiet && $urandom_range(0, 9) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
    endtask

    // Sender: directed rows, then random traffic, then drain and verdict
    initial
    begin
        access_t     acc;
        int unsigned counted;
        in_valid <= 1'b0;
        mode     <= MODE_WRITE;
        address  <= '0;
        data     <= '0;
        counted  = 0;
        do @(posedge clk); while (!rst_n);

        foreach (directed_rows[i])
        begin
            offer(directed_rows[i].acc, directed_rows[i].typed, directed_rows[i].res);
            sender_gap();
        end

        long_hold_req = 1'b1;
        while (counted < RANDOM_ITEMS)
        begin
            if (plan_q.size() == 0)
                plan_sequence();
            acc = plan_q.pop_front();
            offer(acc, 1'b0, NO_RES);
            // writes outside the register window do nothing
            if (acc.mode != MODE_WRITE || acc.addr[15:14] == 2'b10)
                counted++;
            quiet = (counted >= RANDOM_ITEMS - QUIET_ITEMS);
            sender_gap();
        end
        in_valid <= 1'b0;

        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_q.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Receiver: one long hold to back up the pipe, then short random stalls
    initial
    begin
        logic held;
        held = 1'b0;
        out_stall <= 1'b0;
        do @(posedge clk); while (!rst_n);
        forever
        begin
            if (long_hold_req && !held)
            begin
                held = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 5)) @(posedge clk);
            end
            else
            begin
                out_stall <= 1'b0;
                @(posedge clk);
            end
        end
    end

    task automatic flag_field(input string field, input int unsigned want_v,
                              input int unsigned got_v);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s expected %0h, got %0h", $time, field, want_v, got_v);
    endtask

    // Result check and activity tracking
    always @(posedge clk)
    begin : check_results
        mapped_t want;
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;

            if (out_valid && !out_stall)
            begin
                if (expected_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result beat with nothing outstanding", $time);
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (bank != want.bank)
                        flag_field("bank", want.bank, bank);
                    if (offset != want.offset)
                        flag_field("offset", want.offset, offset);
                    if (target != want.target)
                        flag_field("target", want.target, target);
                    if (irq_line != want.irq)
                        flag_field("irq_line", want.irq, irq_line);
                    if (mirroring != want.mirror)
                        flag_field("mirroring", want.mirror, mirroring);
                end
            end
        end
    end

    // Watchdog on cycles with no beat moving on either side
    initial
    begin
        do @(posedge clk); while (idle_cycles < STALL_LIMIT);
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire

[sim.f]
hw/rtl/cbm_pkg.sv
hw/rtl/cbm_regs.sv
hw/rtl/cbm_xlate.sv
hw/rtl/cartridge_bank_mapper_irq_top.sv
tb/cartridge_bank_mapper_irq_top_test.sv
